[hdl/spq_pkg.sv]
`timescale 1ns / 1ps

package spq_pkg;

    localparam int NOTE_W     = 7;
    localparam int CNT_W      = 8;
    localparam int OFS_W      = 8;
    localparam int MASK_W     = 12;
    localparam int PC_W       = 4;
    localparam int SEL_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_BOUND_A     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOUND_B     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROOT        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CUSTOM_MASK = 3'd4;

    localparam logic [SEL_W-1:0] SCALE_CUSTOM = 4'd14;

    // bit k = k semitones above the root; the unused code repeats minor pentatonic
    localparam logic [MASK_W-1:0] SCALE_MASKS [16] = '{
        12'hAB5, 12'h5AD, 12'h6AD, 12'h5AB, 12'hAD5, 12'h6B5, 12'h56B, 12'h295,
        12'h4A9, 12'h4E9, 12'hFFF, 12'h9CD, 12'h555, 12'hB6D, 12'h000, 12'h4A9
    };

    typedef struct packed {
        logic [NOTE_W-1:0] low;
        logic [NOTE_W-1:0] high;
        logic [PC_W-1:0]   root_pc;
        logic [MASK_W-1:0] mask;
    } t_note_cfg;

    // token passed down the cell row: count pass (sel = 0) or select pass (sel = 1)
    typedef struct packed {
        logic              vld;
        logic              sel;
        logic [CNT_W-1:0]  cnt;
        logic [NOTE_W-1:0] note;
    } t_tok;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SCALE,
        S_CLAMP,
        S_SELECT,
        S_OUT
    } t_state;

    function automatic logic [PC_W-1:0] mod12(input logic [NOTE_W-1:0] n);
        logic [NOTE_W-1:0] r;
        r = n;
        if (r >= 7'd96) r = r - 7'd96;
        if (r >= 7'd48) r = r - 7'd48;
        if (r >= 7'd24) r = r - 7'd24;
        if (r >= 7'd12) r = r - 7'd12;
        return r[PC_W-1:0];
    endfunction

endpackage

[hdl/spq_ifs.sv]
`timescale 1ns / 1ps

interface spq_in_if #(
    parameter int LEVEL_W = 17
);
    logic                     valid;
    logic                     ready;
    logic [LEVEL_W-1:0]       level;
    logic signed [7:0]        degree_offset;

    modport source (output valid, output level, output degree_offset, input ready);
    modport sink   (input valid, input level, input degree_offset, output ready);
endinterface

interface spq_out_if;
    logic       valid;
    logic       ready;
    logic [6:0] note;
    logic       empty_set;

    modport source (output valid, output note, output empty_set, input ready);
    modport sink   (input valid, input note, input empty_set, output ready);
endinterface

interface spq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[hdl/spq_cell.sv]
`timescale 1ns / 1ps

module spq_cell
    import spq_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_note_cfg i_cfg,
    input  t_tok      i_tok,
    output t_tok      o_tok
);

    localparam logic [NOTE_W-1:0] CELL_NOTE = NOTE_W'(CELL_IDX);
    localparam logic [PC_W-1:0]   CELL_PC   = PC_W'(CELL_IDX % 12);

    logic [PC_W:0]      pc_sum;
    logic [PC_W-1:0]    pc;
    logic               member;
    logic               r_mem;
    logic [CNT_W-1:0]   r_rank;
    t_tok               r_tok;
    t_tok               n_tok;

    always_comb begin
        pc_sum = {1'b0, CELL_PC} + 5'd12 - {1'b0, i_cfg.root_pc};
        if (pc_sum >= 5'd12) begin
            pc = PC_W'(pc_sum - 5'd12);
        end else begin
            pc = pc_sum[PC_W-1:0];
        end
        member = (CELL_NOTE >= i_cfg.low) && (CELL_NOTE <= i_cfg.high) && i_cfg.mask[pc];
    end

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld) begin
            if (!i_tok.sel) begin
                n_tok.cnt = i_tok.cnt + CNT_W'(member);
            end else if (r_mem && (r_rank == i_tok.cnt)) begin
                n_tok.note = CELL_NOTE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tok.vld && !i_tok.sel) begin
            r_mem  <= member;
            r_rank <= i_tok.cnt;
        end
    end

    assign o_tok = r_tok;

endmodule

[hdl/spq_ctrl.sv]
`timescale 1ns / 1ps

module spq_ctrl
    import spq_pkg::*;
#(
    parameter int NOTE_SPAN       = 128,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spq_in_if.sink        i_in,
    spq_out_if.source     o_out,
    spq_cfg_if.sink       i_cfg,
    output t_note_cfg     o_cell_cfg,
    output t_tok          o_head,
    input  t_tok          i_tail
);

    localparam int LEVEL_W = LEVEL_FRAC_BITS + 1;
    localparam int PROD_W  = LEVEL_W + CNT_W;
    localparam int SUM_W   = CNT_W + 2;
    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << LEVEL_FRAC_BITS;
    localparam logic [NOTE_W-1:0]  MAX_NOTE  = NOTE_W'(NOTE_SPAN - 1);

    t_state              r_state;
    t_state              n_state;

    logic [NOTE_W-1:0]   r_bound_a;
    logic [NOTE_W-1:0]   r_bound_b;
    logic [NOTE_W-1:0]   r_root;
    logic [SEL_W-1:0]    r_scale;
    logic [MASK_W-1:0]   r_custom;

    t_note_cfg           r_cell_cfg;
    t_note_cfg           n_cell_cfg;
    t_tok                r_head;
    t_tok                n_head;
    logic [LEVEL_W-1:0]  r_level;
    logic signed [OFS_W-1:0] r_offset;
    logic [CNT_W-1:0]    r_count;
    logic [PROD_W-1:0]   r_prod;
    logic [NOTE_W-1:0]   r_note;
    logic                r_empty;

    logic                in_acc;
    logic [NOTE_W-1:0]   a_sat;
    logic [NOTE_W-1:0]   b_sat;
    logic [CNT_W:0]      idx_raw;
    logic [CNT_W-1:0]    cnt_m1;
    logic [CNT_W-1:0]    idx_lim;
    logic signed [SUM_W-1:0] idx_sum;
    logic [CNT_W-1:0]    idx_fin;

    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_a <= 7'd0;
            r_bound_b <= 7'd127;
            r_root    <= 7'd0;
            r_scale   <= 4'd0;
            r_custom  <= 12'd0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_BOUND_A:     r_bound_a <= i_cfg.data[NOTE_W-1:0];
                REG_BOUND_B:     r_bound_b <= i_cfg.data[NOTE_W-1:0];
                REG_ROOT:        r_root    <= i_cfg.data[NOTE_W-1:0];
                REG_SCALE:       r_scale   <= i_cfg.data[SEL_W-1:0];
                REG_CUSTOM_MASK: r_custom  <= i_cfg.data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        a_sat = (r_bound_a > MAX_NOTE) ? MAX_NOTE : r_bound_a;
        b_sat = (r_bound_b > MAX_NOTE) ? MAX_NOTE : r_bound_b;
        n_cell_cfg.low     = (a_sat < b_sat) ? a_sat : b_sat;
        n_cell_cfg.high    = (a_sat < b_sat) ? b_sat : a_sat;
        n_cell_cfg.root_pc = mod12(r_root);
        n_cell_cfg.mask    = (r_scale == SCALE_CUSTOM) ? r_custom : SCALE_MASKS[r_scale];
    end

    // index arithmetic for the select pass
    always_comb begin
        idx_raw = r_prod[PROD_W-1:LEVEL_FRAC_BITS];
        cnt_m1  = r_count - 8'd1;
        idx_lim = (idx_raw > {1'b0, cnt_m1}) ? cnt_m1 : idx_raw[CNT_W-1:0];
        idx_sum = $signed({2'b00, idx_lim})
                + $signed({{(SUM_W - OFS_W){r_offset[OFS_W-1]}}, r_offset});
        if (idx_sum < 0) begin
            idx_fin = '0;
        end else if (idx_sum > $signed({2'b00, cnt_m1})) begin
            idx_fin = cnt_m1;
        end else begin
            idx_fin = idx_sum[CNT_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_COUNT;
            S_COUNT: begin
                if (i_tail.vld && !i_tail.sel) begin
                    n_state = (i_tail.cnt == '0) ? S_OUT : S_SCALE;
                end
            end
            S_SCALE:  n_state = S_CLAMP;
            S_CLAMP:  n_state = S_SELECT;
            S_SELECT: if (i_tail.vld && i_tail.sel) n_state = S_OUT;
            S_OUT:    if (o_out.ready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        n_head      = '0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready = 1'b1;
                n_head.vld = i_in.valid;
            end
            S_CLAMP: begin
                n_head.vld = 1'b1;
                n_head.sel = 1'b1;
                n_head.cnt = idx_fin;
            end
            S_OUT:   o_out.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_level    <= (i_in.level > LEVEL_ONE) ? LEVEL_ONE : i_in.level;
            r_offset   <= i_in.degree_offset;
            r_cell_cfg <= n_cell_cfg;
        end
        if (r_state == S_COUNT && i_tail.vld && !i_tail.sel) begin
            r_count <= i_tail.cnt;
            r_note  <= r_cell_cfg.low;
            r_empty <= (i_tail.cnt == '0);
        end
        if (r_state == S_SCALE) begin
            r_prod <= PROD_W'(r_level) * PROD_W'(r_count);
        end
        if (r_state == S_SELECT && i_tail.vld && i_tail.sel) begin
            r_note  <= i_tail.note;
            r_empty <= 1'b0;
        end
    end

    assign o_out.note      = r_note;
    assign o_out.empty_set = r_empty;
    assign o_cell_cfg      = r_cell_cfg;
    assign o_head          = r_head;

endmodule

[hdl/scale_pitch_quantizer.sv]
`timescale 1ns / 1ps

// channel   dir   handshake     payload
// i_in      in    valid/ready   level, degree_offset
// o_out     out   valid/ready   note, empty_set
// i_cfg     in    valid/ready   index, data (always ready)
//
// One transaction at a time. A token runs the NOTE_SPAN-cell row twice
// (count pass, then select pass), or only once when no note fits the scale.
// i_rst_n is synchronous; state, config and token registers take their reset values, the row empties.
// The result holds in its output register while o_out.ready is low.

module scale_pitch_quantizer
    import spq_pkg::*;
#(
    parameter int NOTE_SPAN       = 128,
    parameter int LEVEL_FRAC_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spq_in_if.sink    i_in,
    spq_out_if.source o_out,
    spq_cfg_if.sink   i_cfg
);

    t_note_cfg cell_cfg;
    t_tok      chain [NOTE_SPAN+1];

    spq_ctrl #(
        .NOTE_SPAN       (NOTE_SPAN),
        .LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_out      (o_out),
        .i_cfg      (i_cfg),
        .o_cell_cfg (cell_cfg),
        .o_head     (chain[0]),
        .i_tail     (chain[NOTE_SPAN])
    );

    for (genvar k = 0; k < NOTE_SPAN; k++) begin : g_cell
        spq_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cfg   (cell_cfg),
            .i_tok   (chain[k]),
            .o_tok   (chain[k+1])
        );
    end

endmodule
